>>> rtl/lst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants for the launch split timer.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int SESSION_COUNT_DEF = 2;

  localparam int DIV_QW = 26;              // quotient bits, covers dt_max * 1000
  localparam int DIV_NW = 58;              // dividend bits
  localparam int DIV_DW = 32;              // divisor bits

  localparam logic [16:0] MPH_NUM   = 17'd100000;
  localparam logic [17:0] MPH_DEN   = 18'd160934;
  localparam logic [9:0]  US_PER_MS = 10'd1000;

  localparam logic [31:0] SHORT_RST  = 32'd131674;
  localparam logic [31:0] LONG_RST   = 32'd2896848;
  localparam logic [8:0]  TARGET_RST = 9'd100;
  localparam logic [13:0] RPM_RST    = 14'd5000;
  localparam logic [8:0]  CREEP_RST  = 9'd2;
  localparam logic [15:0] GAP_RST    = 16'd500;

  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_SHORT  = 3'd0,
    REG_LONG   = 3'd1,
    REG_TARGET = 3'd2,
    REG_RPM    = 3'd3,
    REG_CREEP  = 3'd4,
    REG_GAP    = 3'd5,
    REG_MPH    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] short_split_distance;
    logic [31:0] long_split_distance;
    logic [8:0]  target_speed;
    logic [13:0] launch_rpm_limit;
    logic [8:0]  creep_speed;
    logic [15:0] max_gap_ms;
    logic        use_mph;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [8:0]  speed_kph;
    logic [13:0] engine_rpm;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic        session;
    logic        armed;
    logic        racing;
    logic [31:0] short_split_us;
    logic [31:0] speed_split_us;
    logic [31:0] long_split_us;
    logic [2:0]  splits_done;
    logic [8:0]  peak_speed;
    logic [8:0]  shown_speed;
    logic        run_finished;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MPH,
    ST_MPH_WAIT,
    ST_EVAL,
    ST_SCALE,
    ST_CHK,
    ST_MUL,
    ST_DIV,
    ST_DIV_WAIT,
    ST_WRITE,
    ST_FINAL,
    ST_OUT
  } state_t;

endpackage

>>> rtl/launch_split_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// launch_split_timer
// Drag-race split timer: arming, launch, trapezoid distance, split times.
// ----------------------------------------------------------------------------
// One sample word at a time goes through a sequencer around a bit-serial
// divider. Every sample first runs the km/h to mph division. Each split
// recorded by the word adds a multiply and a division, or neither when its
// fraction is zero. The next word is taken in the cycle after the result is
// loaded into the output register, which holds while the receiver stalls.
module launch_split_timer #(
  parameter int SESSION_COUNT = lst_pkg::SESSION_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  lst_pkg::sample_t            sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output lst_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lst_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lst_pkg::*;

  localparam int SW = (SESSION_COUNT > 1) ? $clog2(SESSION_COUNT) : 1;

  cfg_t   cfg;
  state_t state, state_next;

  sample_t smp;
  logic [8:0]  shown;
  logic [15:0] dt;
  logic [31:0] base;
  logic [41:0] base1000;
  logic [25:0] dt1000;
  logic [31:0] prev_sum, new_sum;
  logic [2:0]  hit, zero;
  logic [1:0]  k;
  logic [57:0] prod;
  logic [25:0] frac;
  logic        good, fin;
  logic [SW-1:0] rep;

  logic          armed, racing;
  logic [31:0]   launch_time, last_time, dist_sum;
  logic [8:0]    prev_speed;
  logic [SW-1:0] sess_idx;
  logic [2:0][31:0] split_time [SESSION_COUNT];
  logic [2:0]    split_valid [SESSION_COUNT];
  logic [8:0]    peak [SESSION_COUNT];

  logic        div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  logic [DIV_QW-1:0] div_q;

  logic [31:0] dt_full, num_sel, den_sel;
  logic [25:0] step;
  logic [32:0] nsum;
  logic [42:0] t_full;
  logic        arm_now, launch_ok;

  lst_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  lst_serial_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  assign sample_ready = (state == ST_IDLE);
  assign div_start    = (state == ST_MPH) || (state == ST_DIV);

  always_comb begin
    case (k)
      2'd0:    begin num_sel = cfg.short_split_distance - prev_sum;
                     den_sel = new_sum - prev_sum; end
      2'd1:    begin num_sel = {23'd0, cfg.target_speed - prev_speed};
                     den_sel = {23'd0, smp.speed_kph - prev_speed}; end
      default: begin num_sel = cfg.long_split_distance - prev_sum;
                     den_sel = new_sum - prev_sum; end
    endcase
  end

  // divisor must hold for the whole division
  assign div_n = (state == ST_MPH) ? DIV_NW'(smp.speed_kph) * DIV_NW'(MPH_NUM) : prod;
  assign div_d = (state == ST_MPH || state == ST_MPH_WAIT) ? DIV_DW'(MPH_DEN) : den_sel;

  assign dt_full   = smp.time_ms - last_time;
  assign step      = (26'(prev_speed) + 26'(smp.speed_kph)) * 26'(dt_full[15:0]);
  assign nsum      = {1'b0, dist_sum} + 33'(step);
  assign arm_now   = armed || (smp.speed_kph == '0);
  assign launch_ok = arm_now && (smp.speed_kph != '0) &&
                     !(smp.engine_rpm > cfg.launch_rpm_limit &&
                       smp.speed_kph < cfg.creep_speed);
  assign t_full    = {1'b0, base1000} + 43'(frac);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (sample_valid) state_next = ST_MPH;
      ST_MPH:      state_next = ST_MPH_WAIT;
      ST_MPH_WAIT: if (div_done) state_next = ST_EVAL;
      ST_EVAL:     state_next = ST_SCALE;
      ST_SCALE:    state_next = good ? ST_CHK : ST_FINAL;
      ST_CHK: begin
        if (k == 2'd3)     state_next = ST_FINAL;
        else if (hit[k])   state_next = zero[k] ? ST_WRITE : ST_MUL;
      end
      ST_MUL:      state_next = ST_DIV;
      ST_DIV:      state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_WRITE;
      ST_WRITE:    state_next = ST_CHK;
      ST_FINAL:    state_next = ST_OUT;
      ST_OUT:      if (!result_valid || result_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      racing       <= 1'b0;
      sess_idx     <= '0;
      result_valid <= 1'b0;
      good         <= 1'b0;
      fin          <= 1'b0;
      k            <= '0;
      for (int s = 0; s < SESSION_COUNT; s++) begin
        split_valid[s] <= '0;
        peak[s]        <= '0;
      end
    end else begin
      if (state == ST_OUT && (!result_valid || result_ready)) result_valid <= 1'b1;
      else if (result_valid && result_ready)                  result_valid <= 1'b0;
      unique case (state)
        ST_EVAL: begin
          fin  <= 1'b0;
          good <= 1'b0;
          if (smp.func) begin
            for (int s = 0; s < SESSION_COUNT; s++) begin
              split_valid[s] <= '0;
              peak[s]        <= '0;
            end
            sess_idx <= '0;
            racing   <= 1'b0;
            armed    <= 1'b1;
          end else if (!racing) begin
            armed <= launch_ok ? 1'b0 : arm_now;
            if (launch_ok) begin
              racing                <= 1'b1;
              split_valid[sess_idx] <= '0;
              peak[sess_idx]        <= '0;
            end
          end else if (dt_full != '0 && dt_full <= 32'(cfg.max_gap_ms)) begin
            good <= 1'b1;
          end
        end
        ST_SCALE: k <= '0;
        ST_CHK:   if (k != 2'd3 && !hit[k]) k <= k + 1'b1;
        ST_WRITE: begin
          split_valid[sess_idx][k] <= 1'b1;
          if (k == 2'd2) fin <= 1'b1;
          k <= k + 1'b1;
        end
        ST_FINAL: begin
          if (good) begin
            if (shown > peak[sess_idx]) peak[sess_idx] <= shown;
            if (fin) begin
              racing   <= 1'b0;
              sess_idx <= (sess_idx == SW'(SESSION_COUNT - 1)) ? '0 : sess_idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath and run registers
  always_ff @(posedge clk) begin
    if (rst) begin
      launch_time <= '0;
      last_time   <= '0;
      dist_sum    <= '0;
      prev_speed  <= '0;
    end else begin
      unique case (state)
        ST_IDLE:     if (sample_valid) smp <= sample;
        ST_MPH_WAIT: if (div_done) shown <= cfg.use_mph ? div_q[8:0] : smp.speed_kph;
        ST_EVAL: begin
          if (smp.func) begin
            dist_sum <= '0;
          end else if (!racing) begin
            if (launch_ok) begin
              launch_time <= smp.time_ms;
              last_time   <= smp.time_ms;
              dist_sum    <= '0;
              prev_speed  <= '0;
            end
          end else if (dt_full == '0 || dt_full > 32'(cfg.max_gap_ms)) begin
            last_time <= smp.time_ms;
          end else begin
            dt       <= dt_full[15:0];
            prev_sum <= dist_sum;
            new_sum  <= nsum[32] ? '1 : nsum[31:0];
            base     <= smp.time_ms - launch_time - dt_full;
          end
        end
        ST_SCALE: begin
          base1000 <= 42'(base) * 42'(US_PER_MS);
          dt1000   <= 26'(dt) * 26'(US_PER_MS);
          if (good) dist_sum <= new_sum;
          hit[0]  <= !split_valid[sess_idx][0] && new_sum >= cfg.short_split_distance;
          hit[1]  <= !split_valid[sess_idx][1] && smp.speed_kph >= cfg.target_speed;
          hit[2]  <= !split_valid[sess_idx][2] && new_sum >= cfg.long_split_distance;
          zero[0] <= prev_sum >= cfg.short_split_distance || new_sum <= prev_sum;
          zero[1] <= !(smp.speed_kph > prev_speed && cfg.target_speed > prev_speed);
          zero[2] <= prev_sum >= cfg.long_split_distance || new_sum <= prev_sum;
        end
        ST_CHK:      frac <= '0;
        ST_MUL:      prod <= 58'(num_sel) * 58'(dt1000);
        ST_DIV_WAIT: if (div_done) frac <= div_q;
        ST_WRITE:    split_time[sess_idx][k] <= (t_full[42:32] != '0) ? '1 : t_full[31:0];
        ST_FINAL: begin
          rep <= sess_idx;
          if (good) begin
            prev_speed <= smp.speed_kph;
            last_time  <= smp.time_ms;
          end
        end
        ST_OUT: begin
          if (!result_valid || result_ready) begin
            result.session        <= sess_idx[0];
            result.armed          <= armed;
            result.racing         <= racing;
            result.short_split_us <= split_valid[rep][0] ? split_time[rep][0] : '0;
            result.speed_split_us <= split_valid[rep][1] ? split_time[rep][1] : '0;
            result.long_split_us  <= split_valid[rep][2] ? split_time[rep][2] : '0;
            result.splits_done    <= split_valid[rep];
            result.peak_speed     <= peak[rep];
            result.shown_speed    <= shown;
            result.run_finished   <= fin;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while waiting");
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second word taken while busy");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    sample_ready |-> !div_busy)
    else $error("divider running while idle");
`endif

endmodule

>>> rtl/lst_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_serial_div
// Bit-serial restoring divider, one quotient bit per cycle.
// Requires dividend < divisor * 2**DIV_QW.
// ----------------------------------------------------------------------------
module lst_serial_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lst_pkg::DIV_NW-1:0] dividend,
  input  logic [lst_pkg::DIV_DW-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [lst_pkg::DIV_QW-1:0] quotient
);
  import lst_pkg::*;

  localparam int CW = $clog2(DIV_QW + 1);

  logic [DIV_DW-1:0] rem;
  logic [DIV_QW-1:0] dvd_sh;
  logic [CW-1:0]     cnt;
  logic [DIV_DW:0]   trial;
  logic              take;

  assign trial = {rem, dvd_sh[DIV_QW-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[DIV_NW-1:DIV_QW];
      dvd_sh   <= dividend[DIV_QW-1:0];
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? DIV_DW'(trial - {1'b0, divisor}) : trial[DIV_DW-1:0];
      dvd_sh   <= {dvd_sh[DIV_QW-2:0], 1'b0};
      quotient <= {quotient[DIV_QW-2:0], take};
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a running division");
  a_start_runs: assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("divider did not start");
`endif

endmodule

>>> rtl/lst_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module lst_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lst_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lst_pkg::cfg_t               cfg
);
  import lst_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_split_distance <= SHORT_RST;
      cfg.long_split_distance  <= LONG_RST;
      cfg.target_speed         <= TARGET_RST;
      cfg.launch_rpm_limit     <= RPM_RST;
      cfg.creep_speed          <= CREEP_RST;
      cfg.max_gap_ms           <= GAP_RST;
      cfg.use_mph              <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_SHORT:  cfg.short_split_distance <= pwdata;
        REG_LONG:   cfg.long_split_distance  <= pwdata;
        REG_TARGET: cfg.target_speed         <= pwdata[8:0];
        REG_RPM:    cfg.launch_rpm_limit     <= pwdata[13:0];
        REG_CREEP:  cfg.creep_speed          <= pwdata[8:0];
        REG_GAP:    cfg.max_gap_ms           <= pwdata[15:0];
        REG_MPH:    cfg.use_mph              <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHORT:  prdata = cfg.short_split_distance;
      REG_LONG:   prdata = cfg.long_split_distance;
      REG_TARGET: prdata = {23'd0, cfg.target_speed};
      REG_RPM:    prdata = {18'd0, cfg.launch_rpm_limit};
      REG_CREEP:  prdata = {23'd0, cfg.creep_speed};
      REG_GAP:    prdata = {16'd0, cfg.max_gap_ms};
      REG_MPH:    prdata = {31'd0, cfg.use_mph};
      default:    prdata = '0;
    endcase
  end

endmodule
